// ===== design/vrp_pkg.sv =====
// Shared types, constants and register map of the vertex rotate and project unit.
// Used by every design module except vrp_checker; depends on nothing.
package vrp_pkg;

   localparam int COORD_WIDTH_DEF = 24;
   localparam int ROT_GUARD = 8;
   localparam int SCALE_GROW = 18;
   localparam int ROT_FRAC = 14;
   localparam int QUOT_BITS = 18;
   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 2;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int RESULT_W = 49;

   typedef enum logic [2:0] {
      REG_ROT_A         = 3'd0,
      REG_ROT_B         = 3'd1,
      REG_ROT_C         = 3'd2,
      REG_SCALE_XY      = 3'd3,
      REG_SCALE_Z       = 3'd4,
      REG_WORLD_OFFSET  = 3'd5,
      REG_SCREEN_CENTER = 3'd6,
      REG_NEAR_PLANE    = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [31:0] rot_a;
      logic [31:0] rot_b;
      logic [31:0] rot_c;
      logic [31:0] scale_xy;
      logic [15:0] scale_z;
      logic [59:0] world_offset;
      logic [31:0] screen_center;
      logic [19:0] near_plane;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      rot_a:         32'h4000_0000,
      rot_b:         32'h4000_0000,
      rot_c:         32'h4000_0000,
      scale_xy:      32'h1F40_1F40,
      scale_z:       16'h0500,
      world_offset:  60'h0_0000_0000_0FBA00,
      screen_center: 32'h03C0_021C,
      near_plane:    20'hF9C00
   };

   localparam logic [15:0] SAT_POS = 16'h7FFF;
   localparam logic [15:0] SAT_NEG = 16'h8000;
   localparam logic [15:0] RAD_MAX = 16'hFFFF;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_status_type;

endpackage

// ===== design/vrp_fifo.sv =====
// Small first-in first-out queue built from registers, with show-ahead read.
// Depends on vrp_pkg for the status structure.
module vrp_fifo #(
   parameter int WIDTH = vrp_pkg::RESULT_W,
   parameter int DEPTH = vrp_pkg::OUT_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          wdata,
   input  logic                      pop,
   output logic [WIDTH-1:0]          rdata,
   output vrp_pkg::fifo_status_type  status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== design/vrp_front.sv =====
// Front pipeline: three rotations, axis scaling, world offset and near-plane shift of one vertex.
// Depends on vrp_pkg; feeds the middle queue of the top level.
module vrp_front #(
   parameter int COORD_WIDTH = vrp_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          in_valid,
   input  logic signed [COORD_WIDTH-1:0] pos_x,
   input  logic signed [COORD_WIDTH-1:0] pos_y,
   input  logic signed [COORD_WIDTH-1:0] pos_z,
   input  logic [15:0]                   radius,
   input  vrp_pkg::cfg_type              cfg,
   output logic                          out_valid,
   output logic signed [COORD_WIDTH+vrp_pkg::ROT_GUARD+vrp_pkg::SCALE_GROW-1:0] out_x,
   output logic signed [COORD_WIDTH+vrp_pkg::ROT_GUARD+vrp_pkg::SCALE_GROW-1:0] out_y,
   output logic signed [COORD_WIDTH+vrp_pkg::ROT_GUARD+vrp_pkg::SCALE_GROW-1:0] out_d,
   output logic [15:0]                   out_radius
);

   localparam int RW = COORD_WIDTH + vrp_pkg::ROT_GUARD;
   localparam int PW = RW + 16;
   localparam int XW = RW + vrp_pkg::SCALE_GROW;
   localparam int STAGES = 9;
   localparam logic signed [PW:0] RND = (PW + 1)'(1) << (vrp_pkg::ROT_FRAC - 1);

   function automatic logic signed [RW-1:0] rnd14(input logic signed [PW-1:0] a,
                                                  input logic signed [PW-1:0] b,
                                                  input logic sub);
      logic signed [PW:0] s;
      s = sub ? ((PW + 1)'(a) - (PW + 1)'(b)) : ((PW + 1)'(a) + (PW + 1)'(b));
      s = s + RND;
      return s[RW+vrp_pkg::ROT_FRAC-1:vrp_pkg::ROT_FRAC];
   endfunction

   logic signed [15:0] ca, sa, cb, sb, cc, sc;
   logic signed [16:0] zx, zy, zz;
   logic signed [19:0] ox, oy, oz, np;
   logic signed [27:0] ox_sh, oy_sh;
   logic signed [20:0] dz;
   logic signed [32:0] dz_sh;

   assign ca = cfg.rot_a[31:16];
   assign sa = cfg.rot_a[15:0];
   assign cb = cfg.rot_b[31:16];
   assign sb = cfg.rot_b[15:0];
   assign cc = cfg.rot_c[31:16];
   assign sc = cfg.rot_c[15:0];
   assign zx = {1'b0, cfg.scale_xy[31:16]};
   assign zy = {1'b0, cfg.scale_xy[15:0]};
   assign zz = {1'b0, cfg.scale_z};
   assign ox = cfg.world_offset[59:40];
   assign oy = cfg.world_offset[39:20];
   assign oz = cfg.world_offset[19:0];
   assign np = cfg.near_plane;
   assign ox_sh = {ox, 8'b0};
   assign oy_sh = {oy, 8'b0};
   assign dz = 21'(oz) - 21'(np);
   assign dz_sh = {dz, 12'b0};

   logic              valid_ff [STAGES];
   logic [15:0]       r_ff [STAGES];
   logic signed [RW-1:0] x0_ff, y0_ff, z0_ff;
   logic signed [PW-1:0] p1_ff [4], p1_in [4];
   logic signed [RW-1:0] x1_ff;
   logic signed [RW-1:0] x2_ff, y2_ff, z2_ff;
   logic signed [PW-1:0] p3_ff [4], p3_in [4];
   logic signed [RW-1:0] z3_ff;
   logic signed [RW-1:0] x4_ff, y4_ff, z4_ff;
   logic signed [PW-1:0] p5_ff [4], p5_in [4];
   logic signed [RW-1:0] y5_ff;
   logic signed [RW-1:0] x6_ff, y6_ff, z6_ff;
   logic signed [XW-1:0] px7_ff, py7_ff, pz7_ff, px7_in, py7_in, pz7_in;
   logic signed [XW-1:0] x8_ff, y8_ff, d8_ff, x8_in, y8_in, d8_in;

   always_comb begin
      p1_in[0] = z0_ff * sa;
      p1_in[1] = y0_ff * ca;
      p1_in[2] = z0_ff * ca;
      p1_in[3] = y0_ff * sa;
      p3_in[0] = x2_ff * sb;
      p3_in[1] = y2_ff * cb;
      p3_in[2] = x2_ff * cb;
      p3_in[3] = y2_ff * sb;
      p5_in[0] = x4_ff * sc;
      p5_in[1] = z4_ff * cc;
      p5_in[2] = x4_ff * cc;
      p5_in[3] = z4_ff * sc;
      px7_in = x6_ff * zx;
      py7_in = y6_ff * zy;
      pz7_in = z6_ff * zz;
      x8_in = px7_ff + XW'(ox_sh);
      y8_in = py7_ff + XW'(oy_sh);
      d8_in = pz7_ff + XW'(dz_sh);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (enable) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < STAGES; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         r_ff[0] <= radius;
         for (int i = 1; i < STAGES; i++) begin
            r_ff[i] <= r_ff[i-1];
         end
         x0_ff <= RW'(pos_x);
         y0_ff <= RW'(pos_y);
         z0_ff <= RW'(pos_z);
         p1_ff <= p1_in;
         x1_ff <= x0_ff;
         y2_ff <= rnd14(p1_ff[0], p1_ff[1], 1'b0);
         z2_ff <= rnd14(p1_ff[2], p1_ff[3], 1'b1);
         x2_ff <= x1_ff;
         p3_ff <= p3_in;
         z3_ff <= z2_ff;
         y4_ff <= rnd14(p3_ff[0], p3_ff[1], 1'b0);
         x4_ff <= rnd14(p3_ff[2], p3_ff[3], 1'b1);
         z4_ff <= z3_ff;
         p5_ff <= p5_in;
         y5_ff <= y4_ff;
         z6_ff <= rnd14(p5_ff[0], p5_ff[1], 1'b0);
         x6_ff <= rnd14(p5_ff[2], p5_ff[3], 1'b1);
         y6_ff <= y5_ff;
         px7_ff <= px7_in;
         py7_ff <= py7_in;
         pz7_ff <= pz7_in;
         x8_ff <= x8_in;
         y8_ff <= y8_in;
         d8_ff <= d8_in;
      end
   end

   assign out_valid  = valid_ff[STAGES-1];
   assign out_x      = x8_ff;
   assign out_y      = y8_ff;
   assign out_d      = d8_ff;
   assign out_radius = r_ff[STAGES-1];

endmodule

// ===== design/vrp_div.sv =====
// Pipelined restoring divider with floor rounding and a saturated quotient.
// Depends on vrp_pkg; instantiated by vrp_back.
module vrp_div #(
   parameter int NUM_WIDTH = 64,
   parameter int DEN_WIDTH = 58,
   parameter int QB = vrp_pkg::QUOT_BITS
) (
   input  logic                        clock,
   input  logic                        enable,
   input  logic signed [NUM_WIDTH-1:0] dividend,
   input  logic [DEN_WIDTH-1:0]        divisor,
   output logic signed [QB:0]          quotient
);

   localparam int UW = NUM_WIDTH;
   localparam int DW = DEN_WIDTH;
   localparam int HW = UW - QB;
   localparam int CMPW = (HW > DW) ? HW : DW;

   logic [UW-1:0] u1_ff, u1_in;
   logic          n1_ff;
   logic [DW-1:0] d1_ff;

   logic [DW-1:0] rem_ff [QB+1];
   logic [QB-1:0] lo_ff  [QB+1];
   logic [QB-1:0] quo_ff [QB+1];
   logic          neg_ff [QB+1];
   logic          ovf_ff [QB+1];
   logic [DW-1:0] den_ff [QB+1];

   logic [HW-1:0] hi;
   logic          ovf_in;
   logic [QB-1:0] qm;
   logic signed [QB:0] quotient_ff, quotient_in;

   assign u1_in = dividend[NUM_WIDTH-1]
                ? (UW'(-dividend) + UW'(divisor) - UW'(1))
                : UW'(dividend);
   assign hi = u1_ff[UW-1:QB];
   assign ovf_in = CMPW'(hi) >= CMPW'(d1_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         u1_ff <= u1_in;
         n1_ff <= dividend[NUM_WIDTH-1];
         d1_ff <= divisor;
         rem_ff[0] <= DW'(hi);
         lo_ff[0]  <= u1_ff[QB-1:0];
         quo_ff[0] <= '0;
         neg_ff[0] <= n1_ff;
         ovf_ff[0] <= ovf_in;
         den_ff[0] <= d1_ff;
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_step
      logic [DW:0]   t;
      logic          ge;
      logic [DW-1:0] rem_in;
      assign t = {rem_ff[k], lo_ff[k][QB-1]};
      assign ge = t >= {1'b0, den_ff[k]};
      assign rem_in = ge ? DW'(t - {1'b0, den_ff[k]}) : t[DW-1:0];
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k+1] <= rem_in;
            lo_ff[k+1]  <= {lo_ff[k][QB-2:0], 1'b0};
            quo_ff[k+1] <= {quo_ff[k][QB-2:0], ge};
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
            den_ff[k+1] <= den_ff[k];
         end
      end
   end

   assign qm = ovf_ff[QB] ? '1 : quo_ff[QB];
   assign quotient_in = neg_ff[QB] ? -{1'b0, qm} : {1'b0, qm};

   always_ff @(posedge clock) begin
      if (enable) begin
         quotient_ff <= quotient_in;
      end
   end

   assign quotient = quotient_ff;

endmodule

// ===== design/vrp_back.sv =====
// Back pipeline: perspective divides, centering and saturation of one vertex, zeroed behind the near plane.
// Depends on vrp_pkg and vrp_div; fed from the middle queue of the top level.
module vrp_back #(
   parameter int COORD_WIDTH = vrp_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          in_valid,
   input  logic signed [COORD_WIDTH+vrp_pkg::ROT_GUARD+vrp_pkg::SCALE_GROW-1:0] in_x,
   input  logic signed [COORD_WIDTH+vrp_pkg::ROT_GUARD+vrp_pkg::SCALE_GROW-1:0] in_y,
   input  logic signed [COORD_WIDTH+vrp_pkg::ROT_GUARD+vrp_pkg::SCALE_GROW-1:0] in_d,
   input  logic [15:0]                   in_radius,
   input  vrp_pkg::cfg_type              cfg,
   output logic                          out_valid,
   output logic [15:0]                   screen_x,
   output logic [15:0]                   screen_y,
   output logic [15:0]                   screen_radius,
   output logic                          in_front
);

   localparam int XW = COORD_WIDTH + vrp_pkg::ROT_GUARD + vrp_pkg::SCALE_GROW;
   localparam int NW = XW + 7;
   localparam int DW = XW + 1;
   localparam int QB = vrp_pkg::QUOT_BITS;
   localparam int LAT = QB + 3;
   localparam int SUM_W = QB + 2;

   logic signed [NW-1:0] nx_ff, ny_ff, nr_ff, nx_in, ny_in, nr_in, d_ext;
   logic [DW-1:0]        m_ff;
   logic                 valid_ff [LAT+1];
   logic                 behind_ff [LAT+1];
   logic                 behind_in;
   logic signed [QB:0]   qx, qy, qr;
   logic signed [SUM_W-1:0] sx, sy;
   logic [15:0]          cx, cy, sat_x, sat_y, sat_r;

   assign d_ext = NW'(in_d);
   assign nx_in = {{2{in_x[XW-1]}}, in_x, 5'b0} + d_ext;
   assign ny_in = d_ext - {{2{in_y[XW-1]}}, in_y, 5'b0};
   assign nr_in = {{(NW-37){1'b0}}, in_radius, 21'b0} + d_ext;
   assign behind_in = in_d[XW-1] || (in_d == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (enable) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i <= LAT; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         nx_ff <= nx_in;
         ny_ff <= ny_in;
         nr_ff <= nr_in;
         m_ff  <= {in_d, 1'b0};
         behind_ff[0] <= behind_in;
         for (int i = 1; i <= LAT; i++) begin
            behind_ff[i] <= behind_ff[i-1];
         end
      end
   end

   vrp_div #(.NUM_WIDTH(NW), .DEN_WIDTH(DW), .QB(QB)) u_div_x (
      .clock(clock), .enable(enable), .dividend(nx_ff), .divisor(m_ff), .quotient(qx)
   );

   vrp_div #(.NUM_WIDTH(NW), .DEN_WIDTH(DW), .QB(QB)) u_div_y (
      .clock(clock), .enable(enable), .dividend(ny_ff), .divisor(m_ff), .quotient(qy)
   );

   vrp_div #(.NUM_WIDTH(NW), .DEN_WIDTH(DW), .QB(QB)) u_div_r (
      .clock(clock), .enable(enable), .dividend(nr_ff), .divisor(m_ff), .quotient(qr)
   );

   assign cx = cfg.screen_center[31:16];
   assign cy = cfg.screen_center[15:0];
   assign sx = $signed({{(SUM_W-16){1'b0}}, cx}) + {qx[QB], qx};
   assign sy = $signed({{(SUM_W-16){1'b0}}, cy}) + {qy[QB], qy};

   always_comb begin
      if ((&sx[SUM_W-1:15]) || !(|sx[SUM_W-1:15])) begin
         sat_x = sx[15:0];
      end else begin
         sat_x = sx[SUM_W-1] ? vrp_pkg::SAT_NEG : vrp_pkg::SAT_POS;
      end
      if ((&sy[SUM_W-1:15]) || !(|sy[SUM_W-1:15])) begin
         sat_y = sy[15:0];
      end else begin
         sat_y = sy[SUM_W-1] ? vrp_pkg::SAT_NEG : vrp_pkg::SAT_POS;
      end
      sat_r = (|qr[QB:16]) ? vrp_pkg::RAD_MAX : qr[15:0];
   end

   assign out_valid     = valid_ff[LAT];
   assign in_front      = !behind_ff[LAT];
   assign screen_x      = behind_ff[LAT] ? '0 : sat_x;
   assign screen_y      = behind_ff[LAT] ? '0 : sat_y;
   assign screen_radius = behind_ff[LAT] ? '0 : sat_r;

endmodule

// ===== design/vertex_rotate_project_unit.sv =====
// Throughput: one transaction per cycle while neither queue is full, set by the fully pipelined front multipliers
// and the three 18-step divider pipelines in the back part.
// Reset is synchronous: queues and pipelines empty, registers take their reset values.
// Top level; depends on vrp_pkg, vrp_fifo, vrp_front, vrp_div and vrp_back.
module vertex_rotate_project_unit #(
   parameter int COORD_WIDTH = vrp_pkg::COORD_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [COORD_WIDTH-1:0]       req_pos_x,
   input  logic signed [COORD_WIDTH-1:0]       req_pos_y,
   input  logic signed [COORD_WIDTH-1:0]       req_pos_z,
   input  logic [15:0]                         req_radius,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [15:0]                  rsp_screen_x,
   output logic signed [15:0]                  rsp_screen_y,
   output logic [15:0]                         rsp_screen_radius,
   output logic                                rsp_in_front,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [vrp_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [vrp_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [vrp_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);

   localparam int XW = COORD_WIDTH + vrp_pkg::ROT_GUARD + vrp_pkg::SCALE_GROW;
   localparam int MID_W = 3 * XW + 16;

   vrp_pkg::cfg_type        cfg_ff, cfg_in;
   vrp_pkg::reg_index_type  csr_index;
   logic                    csr_write;

   assign pready    = 1'b1;
   assign csr_index = vrp_pkg::reg_index_type'(paddr[5:3]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      case (csr_index)
         vrp_pkg::REG_ROT_A: begin
            prdata = 64'(cfg_ff.rot_a);
            if (csr_write) cfg_in.rot_a = pwdata[31:0];
         end
         vrp_pkg::REG_ROT_B: begin
            prdata = 64'(cfg_ff.rot_b);
            if (csr_write) cfg_in.rot_b = pwdata[31:0];
         end
         vrp_pkg::REG_ROT_C: begin
            prdata = 64'(cfg_ff.rot_c);
            if (csr_write) cfg_in.rot_c = pwdata[31:0];
         end
         vrp_pkg::REG_SCALE_XY: begin
            prdata = 64'(cfg_ff.scale_xy);
            if (csr_write) cfg_in.scale_xy = pwdata[31:0];
         end
         vrp_pkg::REG_SCALE_Z: begin
            prdata = 64'(cfg_ff.scale_z);
            if (csr_write) cfg_in.scale_z = pwdata[15:0];
         end
         vrp_pkg::REG_WORLD_OFFSET: begin
            prdata = 64'(cfg_ff.world_offset);
            if (csr_write) cfg_in.world_offset = pwdata[59:0];
         end
         vrp_pkg::REG_SCREEN_CENTER: begin
            prdata = 64'(cfg_ff.screen_center);
            if (csr_write) cfg_in.screen_center = pwdata[31:0];
         end
         vrp_pkg::REG_NEAR_PLANE: begin
            prdata = 64'(cfg_ff.near_plane);
            if (csr_write) cfg_in.near_plane = pwdata[19:0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= vrp_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   vrp_pkg::fifo_status_type mid_status, out_status;
   logic                     front_en, back_en;
   logic                     front_valid, back_valid;
   logic signed [XW-1:0]     front_x, front_y, front_d, back_x, back_y, back_d;
   logic [15:0]              front_r, back_r;
   logic [MID_W-1:0]         mid_rdata;
   logic [15:0]              res_x, res_y, res_r;
   logic                     res_front;
   logic [vrp_pkg::RESULT_W-1:0] out_rdata;

   assign front_en = !mid_status.full;
   assign back_en  = !out_status.full;
   assign req_full = mid_status.full;

   vrp_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock(clock), .reset(reset), .enable(front_en), .in_valid(req_push),
      .pos_x(req_pos_x), .pos_y(req_pos_y), .pos_z(req_pos_z), .radius(req_radius),
      .cfg(cfg_ff), .out_valid(front_valid), .out_x(front_x), .out_y(front_y),
      .out_d(front_d), .out_radius(front_r)
   );

   vrp_fifo #(.WIDTH(MID_W), .DEPTH(vrp_pkg::MID_DEPTH)) u_mid_queue (
      .clock(clock), .reset(reset), .push(front_valid && front_en),
      .wdata({front_x, front_y, front_d, front_r}),
      .pop(back_en && !mid_status.empty), .rdata(mid_rdata), .status(mid_status)
   );

   assign {back_x, back_y, back_d, back_r} = mid_rdata;

   vrp_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock(clock), .reset(reset), .enable(back_en), .in_valid(!mid_status.empty),
      .in_x(back_x), .in_y(back_y), .in_d(back_d), .in_radius(back_r), .cfg(cfg_ff),
      .out_valid(back_valid), .screen_x(res_x), .screen_y(res_y),
      .screen_radius(res_r), .in_front(res_front)
   );

   vrp_fifo #(.WIDTH(vrp_pkg::RESULT_W), .DEPTH(vrp_pkg::OUT_DEPTH)) u_out_queue (
      .clock(clock), .reset(reset), .push(back_valid && back_en),
      .wdata({res_x, res_y, res_r, res_front}),
      .pop(rsp_pop), .rdata(out_rdata), .status(out_status)
   );

   assign rsp_empty = out_status.empty;
   assign {rsp_screen_x, rsp_screen_y, rsp_screen_radius, rsp_in_front} = out_rdata;

endmodule

// ===== design/vrp_checker.sv =====
// Port-level checks of the vertex rotate and project unit, bound to the top level.
// Depends only on the ports of vertex_rotate_project_unit.
module vrp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [15:0] rsp_screen_x,
   input logic [15:0] rsp_screen_y,
   input logic [15:0] rsp_screen_radius,
   input logic        rsp_in_front
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("Queues are not empty after reset.");

   a_behind_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_in_front) |->
         (rsp_screen_x == '0 && rsp_screen_y == '0 && rsp_screen_radius == '0))
      else $error("A vertex behind the near plane has nonzero screen fields.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_screen_x) && $stable(rsp_screen_y)
          && $stable(rsp_screen_radius) && $stable(rsp_in_front)))
      else $error("A waiting result transaction changed before it was taken.");

endmodule

bind vertex_rotate_project_unit vrp_checker u_vrp_checker (
   .clock(clock), .reset(reset), .req_full(req_full), .rsp_empty(rsp_empty),
   .rsp_pop(rsp_pop), .rsp_screen_x(rsp_screen_x), .rsp_screen_y(rsp_screen_y),
   .rsp_screen_radius(rsp_screen_radius), .rsp_in_front(rsp_in_front)
);

// ===== tb/tb_vertex_rotate_project_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of vertex_rotate_project_unit: directed and random vertices,
// several register settings, results checked against a built-in projection model.
// Depends on vrp_pkg and the design files of the unit.
module tb_vertex_rotate_project_unit;

   localparam int CW = vrp_pkg::COORD_WIDTH_DEF;
   localparam int AW = vrp_pkg::CSR_ADDR_W;
   localparam int DATA_W = vrp_pkg::CSR_DATA_W;
   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_LIMIT = 4000;
   localparam int RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 100;

   typedef struct packed {
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      logic [15:0] sr;
      logic front;
   } screen_point_type;

   typedef struct {
      logic [CW-1:0] px;
      logic [CW-1:0] py;
      logic [CW-1:0] pz;
      logic [15:0] rad;
      bit typed;
      screen_point_type want;
   } vertex_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic signed [CW-1:0] req_pos_x = '0;
   logic signed [CW-1:0] req_pos_y = '0;
   logic signed [CW-1:0] req_pos_z = '0;
   logic [15:0] req_radius = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic signed [15:0] rsp_screen_x;
   logic signed [15:0] rsp_screen_y;
   logic [15:0] rsp_screen_radius;
   logic rsp_in_front;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [AW-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic pready;

   vrp_pkg::cfg_type cfg_model;
   screen_point_type pending_points[$];
   vertex_row_type directed_rows[$];
   bit failed = 1'b0;
   bit no_idle = 1'b0;
   int stall_cycles = 0;

   vertex_rotate_project_unit #(.COORD_WIDTH(CW)) u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && ((n < 0) != (d < 0))) q = q - 1;
      return q;
   endfunction

   function automatic void rotate_pair(logic [31:0] rot_word, longint a, longint b,
                                       output longint p, output longint q);
      longint c;
      longint s;
      c = longint'($signed(rot_word[31:16]));
      s = longint'($signed(rot_word[15:0]));
      p = floor_div(a * s + b * c + 8192, 16384);
      q = floor_div(a * c - b * s + 8192, 16384);
   endfunction

   function automatic longint div_nearest(longint n, longint d);
      return floor_div(2 * n + d, 2 * d);
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic screen_point_type project_vertex(logic [CW-1:0] px, logic [CW-1:0] py,
                                                       logic [CW-1:0] pz, logic [15:0] rad);
      longint x, y, z, t1, t2, bx, by, bd, ox, oy, oz, np;
      screen_point_type pt;
      x = longint'($signed(px));
      y = longint'($signed(py));
      z = longint'($signed(pz));
      rotate_pair(cfg_model.rot_a, z, y, t1, t2);
      y = t1; z = t2;
      rotate_pair(cfg_model.rot_b, x, y, t1, t2);
      y = t1; x = t2;
      rotate_pair(cfg_model.rot_c, x, z, t1, t2);
      z = t1; x = t2;
      ox = longint'($signed(cfg_model.world_offset[59:40]));
      oy = longint'($signed(cfg_model.world_offset[39:20]));
      oz = longint'($signed(cfg_model.world_offset[19:0]));
      np = longint'($signed(cfg_model.near_plane));
      bx = x * longint'(cfg_model.scale_xy[31:16]) + ox * 256;
      by = y * longint'(cfg_model.scale_xy[15:0]) + oy * 256;
      bd = z * longint'(cfg_model.scale_z) + (oz - np) * 4096;
      pt = '0;
      if (bd > 0) begin
         pt.sx = 16'(clamp(longint'(cfg_model.screen_center[31:16]) + div_nearest(bx * 16, bd),
                           -32768, 32767));
         pt.sy = 16'(clamp(longint'(cfg_model.screen_center[15:0]) + div_nearest(-by * 16, bd),
                           -32768, 32767));
         pt.sr = 16'(clamp(div_nearest(longint'(rad) * 1048576, bd), 0, 65535));
         pt.front = 1'b1;
      end
      return pt;
   endfunction

   task automatic write_register(vrp_pkg::reg_index_type idx, logic [63:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= AW'(8 * int'(idx));
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         vrp_pkg::REG_ROT_A: cfg_model.rot_a = value[31:0];
         vrp_pkg::REG_ROT_B: cfg_model.rot_b = value[31:0];
         vrp_pkg::REG_ROT_C: cfg_model.rot_c = value[31:0];
         vrp_pkg::REG_SCALE_XY: cfg_model.scale_xy = value[31:0];
         vrp_pkg::REG_SCALE_Z: cfg_model.scale_z = value[15:0];
         vrp_pkg::REG_WORLD_OFFSET: cfg_model.world_offset = value[59:0];
         vrp_pkg::REG_SCREEN_CENTER: cfg_model.screen_center = value[31:0];
         vrp_pkg::REG_NEAR_PLANE: cfg_model.near_plane = value[19:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_until_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_vertex(logic [CW-1:0] px, logic [CW-1:0] py, logic [CW-1:0] pz,
                              logic [15:0] rad);
      if (!no_idle) begin
         while ($urandom_range(99) < 11) begin
            req_push <= 1'b0;
            @(posedge clock);
         end
      end
      req_push <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      req_radius <= rad;
      @(posedge clock);
      while (req_full) @(posedge clock);
      pending_points.push_back(project_vertex(px, py, pz, rad));
   endtask

   function automatic logic [63:0] random_word64();
      return {32'($urandom), 32'($urandom)};
   endfunction

   function automatic logic [31:0] random_rotation();
      case ($urandom_range(3))
         0: return 32'h4000_0000;
         1: return {16'($urandom_range(0, 16384)), 16'($urandom_range(0, 16384))};
         2: return {16'($urandom_range(0, 16384)), -16'($urandom_range(0, 16384))};
         default: return 32'($urandom);
      endcase
   endfunction

   task automatic load_random_settings();
      write_register(vrp_pkg::REG_ROT_A, {32'($urandom), random_rotation()});
      write_register(vrp_pkg::REG_ROT_B, {32'($urandom), random_rotation()});
      write_register(vrp_pkg::REG_ROT_C, {32'($urandom), random_rotation()});
      write_register(vrp_pkg::REG_SCALE_XY, ($urandom_range(1) == 0) ? random_word64() :
                     {32'($urandom), 16'($urandom_range(0, 16000)), 16'($urandom_range(0, 16000))});
      write_register(vrp_pkg::REG_SCALE_Z, ($urandom_range(1) == 0) ? random_word64() :
                     {48'($urandom), 16'($urandom_range(0, 3000))});
      write_register(vrp_pkg::REG_WORLD_OFFSET, ($urandom_range(1) == 0) ? random_word64() :
                     {4'($urandom), 20'($signed(20'($urandom_range(0, 40000)) - 20'd20000)),
                      20'($signed(20'($urandom_range(0, 40000)) - 20'd20000)),
                      20'($urandom_range(0, 60000))});
      write_register(vrp_pkg::REG_SCREEN_CENTER, ($urandom_range(1) == 0) ? random_word64() :
                     {32'($urandom), 16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000))});
      write_register(vrp_pkg::REG_NEAR_PLANE, ($urandom_range(1) == 0) ? random_word64() :
                     {44'($urandom), -20'($urandom_range(0, 60000))});
   endtask

   function automatic logic [CW-1:0] random_coord();
      case ($urandom_range(3))
         0: return CW'($urandom);
         1: return CW'($signed($urandom_range(0, 65536)) - 32768);
         default: return CW'($signed($urandom_range(0, 1048576)) - 524288);
      endcase
   endfunction

   task automatic add_row(logic [CW-1:0] px, logic [CW-1:0] py, logic [CW-1:0] pz,
                          logic [15:0] rad, bit typed, screen_point_type want);
      vertex_row_type row;
      row.px = px;
      row.py = py;
      row.pz = pz;
      row.rad = rad;
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endtask

   always @(posedge clock) begin
      screen_point_type got;
      screen_point_type want;
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
         if (rsp_pop && !rsp_empty) begin
            got = {rsp_screen_x, rsp_screen_y, rsp_screen_radius, rsp_in_front};
            if (pending_points.size() == 0) begin
               $display("%0t: unexpected result transaction %h", $time, got);
               failed = 1'b1;
            end else begin
               want = pending_points.pop_front();
               if (got.sx !== want.sx) begin
                  $display("%0t: screen_x expected %0d actual %0d", $time, want.sx, got.sx);
                  failed = 1'b1;
               end
               if (got.sy !== want.sy) begin
                  $display("%0t: screen_y expected %0d actual %0d", $time, want.sy, got.sy);
                  failed = 1'b1;
               end
               if (got.sr !== want.sr) begin
                  $display("%0t: screen_radius expected %0d actual %0d", $time, want.sr,
                           got.sr);
                  failed = 1'b1;
               end
               if (got.front !== want.front) begin
                  $display("%0t: in_front expected %0b actual %0b", $time, want.front,
                           got.front);
                  failed = 1'b1;
               end
            end
         end
         rsp_pop <= no_idle ? 1'b1 : ($urandom_range(99) >= 11);
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      screen_point_type centre_point;
      screen_point_type hidden_point;
      logic [CW-1:0] cmax;
      logic [CW-1:0] cmin;
      cfg_model = vrp_pkg::CFG_RESET;
      cmax = {1'b0, {(CW-1){1'b1}}};
      cmin = {1'b1, {(CW-1){1'b0}}};
      centre_point = '{sx: 16'sd960, sy: 16'sd540, sr: 16'd0, front: 1'b1};
      hidden_point = '0;
      add_row('0, '0, '0, 16'd0, 1'b1, centre_point);
      add_row('0, '0, cmin, 16'd0, 1'b1, hidden_point);
      add_row('0, '0, cmin, 16'hFFFF, 1'b1, hidden_point);
      add_row('0, '0, '0, 16'hFFFF, 1'b0, hidden_point);
      add_row(cmax, '0, '0, 16'd1, 1'b0, hidden_point);
      add_row(cmin, '0, '0, 16'd1, 1'b0, hidden_point);
      add_row('0, cmax, '0, 16'd100, 1'b0, hidden_point);
      add_row('0, cmin, '0, 16'd100, 1'b0, hidden_point);
      add_row('0, '0, cmax, 16'hFFFF, 1'b0, hidden_point);
      add_row(cmax, cmax, cmax, 16'hFFFF, 1'b0, hidden_point);
      add_row(cmin, cmin, cmin, 16'hFFFF, 1'b0, hidden_point);
      add_row(CW'(4096), CW'(-4096), CW'(8192), 16'd50, 1'b0, hidden_point);
      add_row('1, '1, '1, 16'd1, 1'b0, hidden_point);
      add_row('0, '0, CW'(-25000), 16'd10, 1'b0, hidden_point);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_vertex(directed_rows[i].px, directed_rows[i].py, directed_rows[i].pz,
                     directed_rows[i].rad);
         if (directed_rows[i].typed) begin
            pending_points.pop_back();
            pending_points.push_back(directed_rows[i].want);
         end
      end
      wait_until_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) begin
            write_register(vrp_pkg::REG_ROT_A, 64'h8000_8000);
            write_register(vrp_pkg::REG_ROT_B, 64'h7FFF_7FFF);
            write_register(vrp_pkg::REG_ROT_C, 64'h8000_7FFF);
            write_register(vrp_pkg::REG_SCALE_XY, 64'hFFFF_FFFF);
            write_register(vrp_pkg::REG_SCALE_Z, 64'hFFFF);
            write_register(vrp_pkg::REG_WORLD_OFFSET, 64'h0FFF_FFFF_FFFF_FFFF);
            write_register(vrp_pkg::REG_SCREEN_CENTER, 64'hFFFF_FFFF);
            write_register(vrp_pkg::REG_NEAR_PLANE, 64'h8_0000);
         end else if (phase == 1) begin
            write_register(vrp_pkg::REG_ROT_A, '0);
            write_register(vrp_pkg::REG_ROT_B, '0);
            write_register(vrp_pkg::REG_ROT_C, '0);
            write_register(vrp_pkg::REG_SCALE_XY, '0);
            write_register(vrp_pkg::REG_SCALE_Z, '0);
            write_register(vrp_pkg::REG_WORLD_OFFSET, 64'h0000_0000_0008_0000);
            write_register(vrp_pkg::REG_SCREEN_CENTER, '0);
            write_register(vrp_pkg::REG_NEAR_PLANE, 64'h7_FFFF);
         end else begin
            load_random_settings();
         end
         no_idle = (phase == 4);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_vertex(random_coord(), random_coord(), random_coord(),
                        ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom));
            if (phase == 3 && n == ITEMS_PER_PHASE / 2) begin
               req_push <= 1'b0;
               @(posedge clock);
               while (pending_points.size() != 0) @(posedge clock);
            end
         end
         no_idle = 1'b0;
         wait_until_drained();
      end

      if (!failed) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
